### rtl/zero_run_encoder_defines.svh
// ----------------------------------------------------------------------------
// Zero-run encoder assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_ENCODER_DEFINES_SVH
`define ZERO_RUN_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ZRE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ZRE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/zre_pkg.sv
// ----------------------------------------------------------------------------
// Zero-run encoder package
// Shared widths, byte codes and the burst record passed to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package zre_pkg;

    localparam int unsigned HEADER_BYTES_DEF = 4;
    localparam int unsigned HP_W             = 3;
    localparam int unsigned BURST_MAX        = 4;
    localparam int unsigned CNT_W            = $clog2(BURST_MAX + 1);
    localparam int unsigned IDX_W            = $clog2(BURST_MAX);

    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] RUN_MAX   = 8'hFF;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      final_flag;
    } burst_t;

endpackage

`default_nettype wire

### rtl/zre_encode.sv
// ----------------------------------------------------------------------------
// Zero-run encoder byte logic
// Turns one registered input byte and the run state into a burst of up to
// four encoded bytes, and computes the next run state.
// ----------------------------------------------------------------------------
`default_nettype none

module zre_encode #(
    parameter int unsigned HEADER_BYTES = zre_pkg::HEADER_BYTES_DEF
) (
    input  wire zre_pkg::byte_t               data_byte,
    input  wire                               final_byte,
    input  wire logic [zre_pkg::HP_W-1:0]     hp,
    input  wire zre_pkg::byte_t               zc,
    output zre_pkg::burst_t                   burst,
    output logic [zre_pkg::HP_W-1:0]          hp_next,
    output zre_pkg::byte_t                    zc_next
);
    import zre_pkg::*;

    logic [CNT_W-1:0] n;

    always_comb begin
        hp_next     = hp;
        zc_next     = zc;
        n           = '0;
        burst.bytes = '0;

        if (hp < HP_W'(HEADER_BYTES)) begin
            burst.bytes[0] = data_byte;
            n              = CNT_W'(1);
            hp_next        = hp + HP_W'(1);
        end else if (data_byte == ZERO_BYTE) begin
            zc_next = zc + 8'd1;
            // count wrapped: emit a full run and restart at one
            if (zc_next == ZERO_BYTE) begin
                burst.bytes[0] = ZERO_BYTE;
                burst.bytes[1] = RUN_MAX;
                n              = CNT_W'(2);
                zc_next        = 8'd1;
            end
        end else begin
            if (zc != ZERO_BYTE) begin
                burst.bytes[0] = ZERO_BYTE;
                burst.bytes[1] = zc;
                burst.bytes[2] = data_byte;
                n              = CNT_W'(3);
            end else begin
                burst.bytes[0] = data_byte;
                n              = CNT_W'(1);
            end
            zc_next = ZERO_BYTE;
        end

        // end of packet: flush pending run, start a new packet
        if (final_byte) begin
            if (zc_next != ZERO_BYTE) begin
                burst.bytes[n[IDX_W-1:0]]            = ZERO_BYTE;
                burst.bytes[n[IDX_W-1:0] + IDX_W'(1)] = zc_next;
                n                                     = n + CNT_W'(2);
            end
            hp_next = '0;
            zc_next = ZERO_BYTE;
        end

        burst.count      = n;
        burst.final_flag = final_byte;
    end

endmodule

`default_nettype wire

### rtl/zre_burst_out.sv
// ----------------------------------------------------------------------------
// Zero-run encoder output stage
// Holds one burst and hands its bytes to m_ one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module zre_burst_out (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  wire zre_pkg::burst_t burst_in,
    output logic                 free,
    output logic                 m_valid,
    input  wire                  m_ready,
    output zre_pkg::byte_t       m_out_byte,
    output logic                 m_burst_end,
    output logic                 m_packet_end
);
    import zre_pkg::*;
    `include "zero_run_encoder_defines.svh"

    logic [BURST_MAX-1:0][7:0] bytes_reg;
    logic                      final_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      busy, last, take;

    assign busy = (cnt_reg != '0);
    assign last = busy && ({1'b0, idx_reg} == (cnt_reg - CNT_W'(1)));
    assign take = busy && m_ready;
    assign free = !busy || (take && last);

    assign m_valid      = busy;
    assign m_out_byte   = bytes_reg[idx_reg];
    assign m_burst_end  = last;
    assign m_packet_end = last && final_reg;

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = burst_in.count;
            idx_next = '0;
        end else if (take) begin
            if (last) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst_in.bytes;
            final_reg <= burst_in.final_flag;
        end
    end

    `ZRE_ASSERT_IMP(a_idx_in_burst, aclk, aresetn, busy, {1'b0, idx_reg} < cnt_reg, "index past burst length")
    `ZRE_ASSERT_IMP(a_load_when_free, aclk, aresetn, load, free && (burst_in.count != '0), "burst loaded over a pending one")
    `ZRE_ASSERT_NXT(a_burst_continues, aclk, aresetn, take && !last, m_valid && (idx_reg == $past(idx_reg) + IDX_W'(1)), "burst cut short")
    `ZRE_ASSERT_IMP(a_short_burst, aclk, aresetn, load, burst_in.count <= CNT_W'(BURST_MAX), "burst too long")

endmodule

`default_nettype wire

### rtl/zero_run_encoder.sv
// ----------------------------------------------------------------------------
// Zero-run encoder, top level
// Packet byte stream in, zero-run-length encoded byte stream out.
// ----------------------------------------------------------------------------
// Input channel s_: one packet byte per transaction, s_final_byte on the last.
// The first HEADER_BYTES bytes pass through; after that, zero runs come out
// as 0x00,count. Output channel m_: one encoded byte per transaction;
// m_burst_end marks the last byte caused by an input byte and m_packet_end
// the last byte of the encoded packet.
// A byte accepted on s_ sits in the input register, moves into the burst
// register once that is free, and is offered on m_ from there.
// Throughput: one input byte per cycle while m_ready is high and each
// yields at most one result. A burst of n bytes (n up to 4) holds the burst
// register until taken; a held-back zero yields nothing and leaves the
// input register at once. Reset empties both registers and clears run state.
// When m_ready is low the burst register holds; the input register takes
// more bytes till one yields output, then s_ready drops until the burst drains.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_run_encoder #(
    parameter int unsigned HEADER_BYTES = zre_pkg::HEADER_BYTES_DEF
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  wire [7:0]      s_data_byte,
    input  wire            s_final_byte,
    output logic           m_valid,
    input  wire            m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_burst_end,
    output logic           m_packet_end
);
    import zre_pkg::*;

    logic            in_valid_reg;
    byte_t           in_data_reg;
    logic            in_final_reg;
    logic [HP_W-1:0] hp_reg, hp_next;
    byte_t           zc_reg, zc_next;
    burst_t          burst;
    logic            free, advance, load;

    zre_encode #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_encode (
        .data_byte (in_data_reg),
        .final_byte(in_final_reg),
        .hp        (hp_reg),
        .zc        (zc_reg),
        .burst     (burst),
        .hp_next   (hp_next),
        .zc_next   (zc_next)
    );

    // an item with no output drains even while a burst is pending
    assign advance = in_valid_reg && ((burst.count == '0) || free);
    assign load    = advance && (burst.count != '0);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            hp_reg       <= '0;
            zc_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                hp_reg <= hp_next;
                zc_reg <= zc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
    end

    zre_burst_out u_burst_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .burst_in    (burst),
        .free        (free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_burst_end (m_burst_end),
        .m_packet_end(m_packet_end)
    );

endmodule

`default_nettype wire
